// ===== rtl/core/hashed_timer_wheel_top_macros.svh =====
// Assertion macros for the hashed timer wheel checker.
// No dependencies; taken in by `include.
`ifndef HASHED_TIMER_WHEEL_TOP_MACROS_SVH
`define HASHED_TIMER_WHEEL_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HTW_AST_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htw assertion failed");

// antecedent implies consequent in the next cycle
`define HTW_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htw assertion failed");

`endif

// ===== rtl/core/htw_pkg.sv =====
// Package for the hashed timer wheel: word types, op codes, command/status.
// No dependencies.
package htw_pkg;

  localparam int MAX_TIMERS_DEF  = 32;
  localparam int WHEEL_SLOTS_DEF = 256;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] delay_ticks;
    logic [31:0] period_ticks;
    logic [15:0] event_code;
    logic [31:0] cancel_handle;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] timer_handle;
    logic [15:0] fired_event;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic idx_inc;
    logic mod_load;
    logic mod_sel_period;
    logic mod_step;
    logic wr_start;
    logic wr_rearm;
    logic clr_valid;
    logic set_pend;
    logic emit_pend;
    logic pend_last;
    logic reply_full;
    logic tick_adv;
  } htw_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_last;
    logic       cur_free;
    logic       cancel_hit;
    logic       tick_hit;
    logic       period_nz;
    logic       pend_v;
    logic       mod_done;
  } htw_stat_t;

endpackage

// ===== rtl/core/htw_ctrl.sv =====
// Sequencer for the hashed timer wheel: walks the table one entry at a time.
// Depends on htw_pkg.
module htw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_op,
  output logic               busy,
  input  htw_pkg::htw_stat_t stat,
  output htw_pkg::htw_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_op != htw_pkg::OP_NONE) begin
          cmd.latch = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        unique case (stat.op)
          htw_pkg::OP_START: begin
            if (stat.cur_free) begin
              cmd.mod_load = 1'b1;
              state_nxt    = S_MOD;
            end else if (stat.idx_last) begin
              cmd.reply_full = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_RD;
            end
          end
          htw_pkg::OP_CANCEL: begin
            if (stat.cancel_hit) begin
              cmd.clr_valid = 1'b1;
              state_nxt     = S_IDLE;
            end else if (stat.idx_last) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_RD;
            end
          end
          default: begin
            if (stat.tick_hit) begin
              cmd.emit_pend = stat.pend_v;
              cmd.set_pend  = 1'b1;
            end
            if (stat.tick_hit && stat.period_nz) begin
              cmd.mod_load       = 1'b1;
              cmd.mod_sel_period = 1'b1;
              state_nxt          = S_MOD;
            end else begin
              cmd.clr_valid = stat.tick_hit;
              if (stat.idx_last) state_nxt = S_FIN;
              else begin
                cmd.idx_inc = 1'b1;
                state_nxt   = S_RD;
              end
            end
          end
        endcase
      end
      S_MOD: begin
        if (stat.mod_done) state_nxt = S_WR;
        else               cmd.mod_step = 1'b1;
      end
      S_WR: begin
        if (stat.op == htw_pkg::OP_START) begin
          cmd.wr_start = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.wr_rearm = 1'b1;
          if (stat.idx_last) state_nxt = S_FIN;
          else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_FIN: begin
        cmd.emit_pend = stat.pend_v;
        cmd.pend_last = 1'b1;
        cmd.tick_adv  = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/htw_dp.sv =====
// Datapath for the hashed timer wheel: entry memories, valid bits, counters,
// reciprocal-multiply slot reducer and result register. Depends on htw_pkg.
module htw_dp #(
  parameter int MAX_TIMERS  = htw_pkg::MAX_TIMERS_DEF,
  parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  htw_pkg::in_word_t   in_word,
  input  htw_pkg::htw_cmd_t   cmd,
  output htw_pkg::htw_stat_t  stat,
  output logic                out_valid,
  output htw_pkg::out_word_t  out_word
);

  localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  // ceil(2^(32+SLOT_W) / slots): quotient exact for any 32-bit dividend
  localparam logic [32:0] SLOT_RCP =
    33'(((64'd1 << (32 + SLOT_W)) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS));

  logic [31:0] exp_mem [MAX_TIMERS];
  logic [31:0] per_mem [MAX_TIMERS];
  logic [15:0] evt_mem [MAX_TIMERS];
  logic [31:0] hdl_mem [MAX_TIMERS];
  logic [SLOT_W-1:0] slt_mem [MAX_TIMERS];

  logic [31:0] exp_rd_r, per_rd_r, hdl_rd_r;
  logic [15:0] evt_rd_r;
  logic [SLOT_W-1:0] slt_rd_r;

  htw_pkg::in_word_t in_r;
  logic [MAX_TIMERS-1:0] valid_r;
  logic [IDX_W-1:0]      idx_r;
  logic [31:0]           tick_r, hctr_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  pend_v_r;
  logic [31:0]           pend_h_r;
  logic [15:0]           pend_e_r;

  // slot reducer: multiply by reciprocal, then subtract quotient times slots
  logic [31:0]       sum_r;
  logic [64:0]       prod_r;
  logic [31:0]       quot;
  logic [SLOT_W-1:0] rem_r;
  logic [1:0]        cnt_r;
  logic [31:0]       addend;

  logic              out_valid_r;
  htw_pkg::out_word_t out_r;

  assign addend = cmd.mod_sel_period ? per_rd_r : in_r.delay_ticks;
  assign quot   = 32'(prod_r >> (32 + SLOT_W));

  always_ff @(posedge clk) begin
    exp_rd_r <= exp_mem[idx_r];
    per_rd_r <= per_mem[idx_r];
    evt_rd_r <= evt_mem[idx_r];
    hdl_rd_r <= hdl_mem[idx_r];
    slt_rd_r <= slt_mem[idx_r];
    if (cmd.wr_start || cmd.wr_rearm) begin
      exp_mem[idx_r] <= sum_r;
      slt_mem[idx_r] <= rem_r;
    end
    if (cmd.wr_start) begin
      per_mem[idx_r] <= in_r.period_ticks;
      evt_mem[idx_r] <= in_r.event_code;
      hdl_mem[idx_r] <= hctr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) in_r <= in_word;
    if (cmd.set_pend) begin
      pend_h_r <= hdl_rd_r;
      pend_e_r <= evt_rd_r;
    end
    if (cmd.mod_load) begin
      sum_r <= tick_r + addend;
    end else if (cmd.mod_step) begin
      if (cnt_r == 2'd2) prod_r <= {33'd0, sum_r} * {32'd0, SLOT_RCP};
      else               rem_r  <= SLOT_W'(sum_r - quot * 32'(WHEEL_SLOTS));
    end
    if (cmd.emit_pend) begin
      out_r <= '{kind: htw_pkg::KIND_FIRE, timer_handle: pend_h_r,
                 fired_event: pend_e_r, last: cmd.pend_last};
    end else if (cmd.reply_full) begin
      out_r <= '{kind: htw_pkg::KIND_REPLY, timer_handle: 32'd0,
                 fired_event: 16'd0, last: 1'b1};
    end else if (cmd.wr_start) begin
      out_r <= '{kind: htw_pkg::KIND_REPLY, timer_handle: hctr_r,
                 fired_event: 16'd0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      idx_r       <= '0;
      tick_r      <= '0;
      slot_r      <= '0;
      hctr_r      <= 32'd1;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_pend || cmd.reply_full || cmd.wr_start;
      if (cmd.latch)        idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.wr_start)  valid_r[idx_r] <= 1'b1;
      if (cmd.clr_valid) valid_r[idx_r] <= 1'b0;
      if (cmd.wr_start) hctr_r <= (hctr_r == 32'hFFFF_FFFF) ? 32'd1 : hctr_r + 32'd1;
      if (cmd.latch || cmd.tick_adv) pend_v_r <= 1'b0;
      else if (cmd.set_pend)         pend_v_r <= 1'b1;
      if (cmd.mod_load)      cnt_r <= 2'd2;
      else if (cmd.mod_step) cnt_r <= cnt_r - 2'd1;
      if (cmd.tick_adv) begin
        tick_r <= tick_r + 32'd1;
        // slot follows tick mod slot count, restarting where the tick wraps
        if (tick_r == 32'hFFFF_FFFF || slot_r == SLOT_W'(WHEEL_SLOTS - 1))
          slot_r <= '0;
        else
          slot_r <= slot_r + 1'b1;
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.op         = in_r.operation;
    stat.idx_last   = (idx_r == IDX_W'(MAX_TIMERS - 1));
    stat.cur_free   = !valid_r[idx_r];
    stat.cancel_hit = valid_r[idx_r] && (hdl_rd_r == in_r.cancel_handle);
    stat.tick_hit   = valid_r[idx_r] && (slt_rd_r == slot_r) && (exp_rd_r <= tick_r);
    stat.period_nz  = (per_rd_r != 32'd0);
    stat.pend_v     = pend_v_r;
    stat.mod_done   = (cnt_r == 2'd0);
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// ===== rtl/core/hashed_timer_wheel_top.sv =====
// Top level of the hashed timer wheel timer table.
// Depends on htw_pkg, htw_ctrl and htw_dp.
//
// Usage notes
//   Input: a command word is taken on a clock edge with start high and busy
//   low. Operations: start timer, cancel timer, advance one tick; code 3 is
//   dropped at once and leaves busy low.
//   Output: each result word sits on out_word for one cycle with out_valid
//   high. The receiver cannot stall; every strobe is a delivered word.
//   A start gives one reply word (handle, 0 when the table is full); cancel
//   gives none; a tick gives one word per fired timer in entry order, the
//   final one flagged last.
//   Sequence: the sequencer walks the table one entry at a time (memory
//   read then evaluate). Expiry slots come from a reciprocal-multiply
//   reducer (sum, multiply, subtract) followed by a write, once per start
//   or per periodic re-arm.
//   Reset: synchronous, active low; clears valid bits, tick and slot count,
//   sets the handle counter to one. Entry memories are not cleared; an entry
//   only takes effect while its valid bit is set.
module hashed_timer_wheel_top #(
  parameter int MAX_TIMERS  = htw_pkg::MAX_TIMERS_DEF,
  parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  htw_pkg::in_word_t  in_word,
  output logic               out_valid,
  output htw_pkg::out_word_t out_word
);

  htw_pkg::htw_cmd_t  cmd;
  htw_pkg::htw_stat_t stat;

  // sequencer: owns the state, issues one command set per cycle
  htw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_word.operation),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // storage, arithmetic and the result register
  htw_dp #(
    .MAX_TIMERS  (MAX_TIMERS),
    .WHEEL_SLOTS (WHEEL_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/core/htw_checker.sv =====
// Port-level checker for the hashed timer wheel, bound to the top level.
// Depends on htw_pkg and hashed_timer_wheel_top_macros.svh.
`include "hashed_timer_wheel_top_macros.svh"

module htw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input htw_pkg::in_word_t  in_word,
  input logic               out_valid,
  input htw_pkg::out_word_t out_word
);

  `HTW_AST_SAME(a_reply_last, out_valid && out_word.kind == htw_pkg::KIND_REPLY, out_word.last)
  `HTW_AST_SAME(a_more_busy, out_valid && !out_word.last, busy)
  `HTW_AST_NEXT(a_accept_busy, start && !busy && in_word.operation != htw_pkg::OP_NONE, busy)
  `HTW_AST_NEXT(a_reply_alone, out_valid && out_word.kind == htw_pkg::KIND_REPLY, !out_valid)
  `HTW_AST_SAME(a_reply_event, out_valid && out_word.kind == htw_pkg::KIND_REPLY, out_word.fired_event == 16'd0)

endmodule

bind hashed_timer_wheel_top htw_checker u_htw_checker (.*);
